### design/battery_monitor_frame_receiver_unit_assert.svh
// assertion macros used by the frame receiver rtl
`ifndef BATTERY_MONITOR_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define BATTERY_MONITOR_FRAME_RECEIVER_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define BMFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BMFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bmfr_pkg.sv
`default_nettype none

package bmfr_pkg;

  // operation codes
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // frame status codes
  localparam logic [1:0] FS_INCOMPLETE = 2'd0;
  localparam logic [1:0] FS_GOOD       = 2'd1;
  localparam logic [1:0] FS_BAD_SUM    = 2'd2;
  localparam logic [1:0] FS_ERROR      = 2'd3;

  // frame layout
  localparam logic [7:0] START_BYTE     = 8'hDD;
  localparam int         FRAME_OVERHEAD = 7;
  localparam int         CHECK_OFFSET   = 4;
  localparam int         LENGTH_OFFSET  = 3;
  localparam int         STATUS_OFFSET  = 2;
  localparam int         COMMAND_OFFSET = 1;

  // frame state apart from the byte count
  typedef struct packed {
    logic [7:0]  len;
    logic        err;
    logic [15:0] sum;
    logic [15:0] cks;
    logic [7:0]  cmd;
  } frame_state_t;

  // report for one chunk end, without the byte count
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  cmd;
    logic [7:0]  len;
    logic [15:0] csum;
    logic [15:0] cks;
  } frame_report_t;

endpackage

`default_nettype wire

### design/bmfr_step.sv
`default_nettype none

module bmfr_step import bmfr_pkg::*; #(
  parameter int CNT_W = 7,
  parameter int CAP   = 100
) (
  input  wire logic               op,
  input  wire logic [7:0]         rx_byte,
  input  wire logic               first,
  input  wire logic               last,
  input  wire logic [CNT_W-1:0]   cnt,
  input  wire frame_state_t       st,
  output logic      [CNT_W-1:0]   cnt_nxt,
  output frame_state_t            st_nxt,
  output logic                    has_res,
  output frame_report_t           res
);

  localparam int CMP_W = ((CNT_W > 8) ? CNT_W : 8) + 2;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(CAP - 2);

  logic             take;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] len_ext;
  logic [CMP_W-1:0] cnt_ext;

  always_comb begin
    cnt_nxt = cnt;
    st_nxt  = st;
    pos_ext = CMP_W'(cnt);
    len_ext = CMP_W'(st.len);
    take    = !st.err && ((cnt != '0) || (first && (rx_byte == START_BYTE)));

    if (op == OP_CLEAR) begin
      cnt_nxt = '0;
      st_nxt  = '0;
    end else if (take) begin
      // overflow is checked on every accepted byte, status byte must be zero
      if (cnt >= CNT_LIMIT) begin
        st_nxt.err = 1'b1;
      end else if ((pos_ext == CMP_W'(STATUS_OFFSET)) && (rx_byte != 8'd0)) begin
        st_nxt.err = 1'b1;
      end else begin
        if (pos_ext == CMP_W'(COMMAND_OFFSET)) begin
          st_nxt.cmd = rx_byte;
        end
        if (pos_ext == CMP_W'(LENGTH_OFFSET)) begin
          st_nxt.len = rx_byte;
        end
        len_ext = CMP_W'(st_nxt.len);
        if ((pos_ext >= CMP_W'(LENGTH_OFFSET)) &&
            (pos_ext <= len_ext + CMP_W'(LENGTH_OFFSET))) begin
          st_nxt.sum = st.sum - {8'd0, rx_byte};
        end
        if ((pos_ext == len_ext + CMP_W'(CHECK_OFFSET)) ||
            (pos_ext == len_ext + CMP_W'(CHECK_OFFSET + 1))) begin
          st_nxt.cks = {st.cks[7:0], rx_byte};
        end
        cnt_nxt = cnt + CNT_W'(1);
      end
    end

    cnt_ext = CMP_W'(cnt_nxt);
    has_res = (op == OP_BYTE) && last;

    res.cmd  = st_nxt.cmd;
    res.len  = st_nxt.len;
    res.csum = st_nxt.sum;
    res.cks  = st_nxt.cks;
    if (st_nxt.err) begin
      res.status = FS_ERROR;
    end else if ((cnt_nxt != '0) &&
                 (cnt_ext == CMP_W'(st_nxt.len) + CMP_W'(FRAME_OVERHEAD))) begin
      res.status = (st_nxt.sum == st_nxt.cks) ? FS_GOOD : FS_BAD_SUM;
    end else begin
      res.status = FS_INCOMPLETE;
    end
  end

endmodule

`default_nettype wire

### design/battery_monitor_frame_receiver_unit.sv
// channel  | direction | handshake           | payload
// in_      | input     | in_valid / in_stall   | operation, rx_byte, chunk_first, chunk_last
// out_     | output    | out_valid / out_stall | frame_status, command_code, payload_length,
//          |           |                       | computed_sum, carried_sum, bytes_held
//
// one request per cycle sustained while in_stall is low; a byte is held in the input register
// and its report is registered into the result register from there
// the frame state update is a few compares, a count and a 16-bit subtract per byte
// rst_n is synchronous, active low; it clears the frame state and both valid flags
// out_stall holds the result register; the input stage stalls only when the
// waiting byte would produce a report and the result register is still full
`default_nettype none

module battery_monitor_frame_receiver_unit import bmfr_pkg::*; #(
  parameter int BUFFER_CAPACITY = 100
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_chunk_first,
  input  wire logic        in_chunk_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_frame_status,
  output logic [7:0]       out_command_code,
  output logic [7:0]       out_payload_length,
  output logic [15:0]      out_computed_sum,
  output logic [15:0]      out_carried_sum,
  output logic [6:0]       out_bytes_held
);

  // byte count never passes capacity minus two, so this width holds it
  localparam int CNT_W = $clog2(BUFFER_CAPACITY);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BUFFER_CAPACITY - 2);

  // input register
  logic       in_vld_r;
  logic       in_op_r;
  logic [7:0] in_byte_r;
  logic       in_first_r;
  logic       in_last_r;

  // frame state
  logic [CNT_W-1:0] cnt_r;
  frame_state_t     st_r;

  // step outputs
  logic [CNT_W-1:0] cnt_nxt;
  frame_state_t     st_nxt;
  logic             step_has_res;
  frame_report_t    step_res;
  logic [CNT_W+6:0] held_ext;

  // result register
  logic          out_vld_r;
  frame_report_t out_res_r;
  logic [6:0]    out_held_r;

  logic proc_go;

  // a byte that gives no report can always move on; a report needs room
  assign proc_go  = in_vld_r && (!step_has_res || !out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !proc_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_op_r    <= in_operation;
      in_byte_r  <= in_rx_byte;
      in_first_r <= in_chunk_first;
      in_last_r  <= in_chunk_last;
    end
  end

  bmfr_step #(
    .CNT_W (CNT_W),
    .CAP   (BUFFER_CAPACITY)
  ) u_step (
    .op      (in_op_r),
    .rx_byte (in_byte_r),
    .first   (in_first_r),
    .last    (in_last_r),
    .cnt     (cnt_r),
    .st      (st_r),
    .cnt_nxt (cnt_nxt),
    .st_nxt  (st_nxt),
    .has_res (step_has_res),
    .res     (step_res)
  );

  // a dropped chunk and a stray byte both leave the state alone, so no
  // separate drop flag is kept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      st_r  <= '0;
    end else if (proc_go) begin
      cnt_r <= cnt_nxt;
      st_r  <= st_nxt;
    end
  end

  // bytes_held shows the count masked to seven bits
  assign held_ext = {7'd0, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc_go && step_has_res) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && step_has_res) begin
      out_res_r  <= step_res;
      out_held_r <= held_ext[6:0];
    end
  end

  assign out_valid          = out_vld_r;
  assign out_frame_status   = out_res_r.status;
  assign out_command_code   = out_res_r.cmd;
  assign out_payload_length = out_res_r.len;
  assign out_computed_sum   = out_res_r.csum;
  assign out_carried_sum    = out_res_r.cks;
  assign out_bytes_held     = out_held_r;

`include "battery_monitor_frame_receiver_unit_assert.svh"

  `BMFR_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_LIMIT, "byte count past capacity")
  `BMFR_ASSERT_NEXT(a_err_sticky, st_r.err && !(proc_go && (in_op_r == OP_CLEAR)), st_r.err, "sticky error dropped without clear")
  `BMFR_ASSERT_NEXT(a_in_hold, in_vld_r && !proc_go, in_vld_r, "waiting byte lost from input stage")
  `BMFR_ASSERT_NOW(a_good_sum, out_vld_r && (out_res_r.status == FS_GOOD), out_res_r.csum == out_res_r.cks, "good status with mismatched checksum")

endmodule

`default_nettype wire
